// ----- hw/rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg: shared widths, register codes and stage payloads
// Types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

  // Field widths
  localparam int RAW_W  = 24;               // raw conversion words
  localparam int CAL_W  = 16;               // calibration words
  localparam int IDX_W  = 3;                // configuration register index
  localparam int TOUT_W = 24;               // temperature result field
  localparam int P_W    = 32;               // pressure result field

  // Internal widths, sized from the value ranges
  localparam int DT_W    = RAW_W + 1;       // dT = D2 - tref*2^8
  localparam int MUL_W   = DT_W + CAL_W + 1; // dT times a calibration word
  localparam int DTSQ_W  = 2 * RAW_W;       // dT^2, never negative
  localparam int TEMP_W  = 20;              // first-order temperature
  localparam int T2_W    = 17;              // second-order temperature term
  localparam int SQ_W    = 35;              // (TEMP-2000)^2 and (TEMP+1500)^2
  localparam int KSQ_W   = SQ_W + 6;        // square times a six-bit constant
  localparam int OS_W    = 44;              // offset and sensitivity
  localparam int SPLIT_W = 20;              // low slice of SENS for the D1 product
  localparam int PROD_W  = 64;              // D1 * SENS
  localparam int ACC_W   = 45;              // D1*SENS/2^21 - OFF

  // Scaling shifts
  localparam int TS_SHIFT   = 23;
  localparam int T2H_SHIFT  = 38;
  localparam int T2L_SHIFT  = 33;
  localparam int OTCO_SHIFT = 6;
  localparam int STCO_SHIFT = 7;
  localparam int OFF_SHIFT  = 17;
  localparam int SENS_SHIFT = 16;
  localparam int K2_SHIFT   = 4;
  localparam int D1_SHIFT   = 21;
  localparam int P_SHIFT    = 15;

  // Temperature thresholds in hundredths of a degree
  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 20'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VLOW = 20'sd1500;

  // Second-order coefficients
  localparam logic [5:0] OFF2_LOW_K   = 6'd61;
  localparam logic [5:0] SENS2_LOW_K  = 6'd29;
  localparam logic [5:0] OFF2_VLOW_K  = 6'd17;
  localparam logic [5:0] SENS2_VLOW_K = 6'd9;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_CAL_SENS       = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAL_OFFSET     = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAL_SENS_TCO   = 3'd2;
  localparam logic [IDX_W-1:0] REG_CAL_OFFSET_TCO = 3'd3;
  localparam logic [IDX_W-1:0] REG_CAL_TREF       = 3'd4;
  localparam logic [IDX_W-1:0] REG_CAL_TEMPSENS   = 3'd5;
  localparam logic [IDX_W-1:0] REG_CAL_LOADED     = 3'd6;

  typedef struct packed {
    logic [CAL_W-1:0] sens;
    logic [CAL_W-1:0] offset;
    logic [CAL_W-1:0] sens_tco;
    logic [CAL_W-1:0] offset_tco;
    logic [CAL_W-1:0] tref;
    logic [CAL_W-1:0] tempsens;
    logic             loaded;
  } cal_t;

  // Front section to correction section
  typedef struct packed {
    logic                     ok;
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic [T2_W-1:0]          t2;
    logic signed [OS_W-1:0]   off1;
    logic signed [OS_W-1:0]   sens1;
  } front_t;

  // Correction section to pressure section
  typedef struct packed {
    logic                     ok;
    logic [RAW_W-1:0]         d1;
    logic signed [TOUT_W-1:0] tout;
    logic signed [OS_W-1:0]   off;
    logic signed [OS_W-1:0]   sens;
  } corr_t;

  typedef struct packed {
    logic                     result_valid;
    logic signed [TOUT_W-1:0] temperature_centi;
    logic signed [P_W-1:0]    pressure_centi;
  } result_t;

endpackage

// ----- hw/rtl/bpc_if.sv -----
// ----------------------------------------------------------------------------
// bpc_if: stream channels of the compensation block
// Raw conversion channel and compensated result channel, valid/ready.
// ----------------------------------------------------------------------------
interface bpc_raw_if import bpc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_pressure;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bpc_comp_if import bpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     result_valid;
  logic signed [TOUT_W-1:0] temperature_centi;
  logic signed [P_W-1:0]    pressure_centi;

  modport source (output valid, result_valid, temperature_centi, pressure_centi,
                  input ready);
  modport sink (input valid, result_valid, temperature_centi, pressure_centi,
                output ready);
endinterface

// ----- hw/rtl/bpc_front.sv -----
// ----------------------------------------------------------------------------
// bpc_front: dT, first-order temperature, T2, first-order OFF and SENS
// Three register stages: difference, products, scaling.
// ----------------------------------------------------------------------------
module bpc_front import bpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cal_t             cal,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] raw_pressure,
  input  logic [RAW_W-1:0] raw_temperature,
  output logic             out_valid,
  input  logic             out_ready,
  output front_t           out_data
);

  logic [2:0] v;
  logic [2:0] en;

  // stage 1
  logic                   s1_ok;
  logic [RAW_W-1:0]       s1_d1;
  logic signed [DT_W-1:0] s1_dt;
  logic signed [DT_W-1:0] dt_c;
  logic                   ok_c;

  // stage 2
  logic                      s2_ok;
  logic [RAW_W-1:0]          s2_d1;
  logic signed [MUL_W-1:0]   s2_pts;
  logic signed [MUL_W-1:0]   s2_potco;
  logic signed [MUL_W-1:0]   s2_pstco;
  logic [DTSQ_W-1:0]         s2_dtsq;
  logic signed [2*DT_W-1:0]  dtsq_c;

  // stage 3
  logic signed [MUL_W-1:0]  pts_b, pts_q;
  logic signed [MUL_W-1:0]  potco_b, potco_q;
  logic signed [MUL_W-1:0]  pstco_b, pstco_q;
  logic signed [TEMP_W-1:0] temp_c;
  logic [DTSQ_W+2:0]        t2h_full;
  logic [DTSQ_W+1:0]        t2l_full;
  logic [T2_W-1:0]          t2_c;
  logic signed [OS_W-1:0]   off1_c, sens1_c;
  front_t                   s3;

  // Each stage moves when it is empty or the next one moves
  assign en[2]     = !v[2] || out_ready;
  assign en[1]     = !v[1] || en[2];
  assign en[0]     = !v[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v[2];
  assign out_data  = s3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  assign dt_c = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.tref, 8'h00});
  assign ok_c = cal.loaded && (raw_pressure != '0) && (raw_temperature != '0);

  assign dtsq_c = (2*DT_W)'(s1_dt) * (2*DT_W)'(s1_dt);

  // Truncate toward zero: bias negative values before the arithmetic shift
  assign pts_b   = s2_pts + $signed({{(MUL_W-TS_SHIFT){1'b0}}, {TS_SHIFT{s2_pts[MUL_W-1]}}});
  assign pts_q   = pts_b >>> TS_SHIFT;
  assign temp_c  = TEMP_REF + $signed(pts_q[TEMP_W-1:0]);

  assign t2h_full = {1'b0, s2_dtsq, 2'b00} + {3'b000, s2_dtsq};
  assign t2l_full = {1'b0, s2_dtsq, 1'b0} + {2'b00, s2_dtsq};
  assign t2_c = (temp_c >= TEMP_REF)
              ? T2_W'(t2h_full[DTSQ_W+2:T2H_SHIFT])
              : T2_W'(t2l_full[DTSQ_W+1:T2L_SHIFT]);

  assign potco_b = s2_potco
                 + $signed({{(MUL_W-OTCO_SHIFT){1'b0}}, {OTCO_SHIFT{s2_potco[MUL_W-1]}}});
  assign potco_q = potco_b >>> OTCO_SHIFT;
  assign pstco_b = s2_pstco
                 + $signed({{(MUL_W-STCO_SHIFT){1'b0}}, {STCO_SHIFT{s2_pstco[MUL_W-1]}}});
  assign pstco_q = pstco_b >>> STCO_SHIFT;

  assign off1_c  = $signed({{(OS_W-CAL_W-OFF_SHIFT){1'b0}}, cal.offset, {OFF_SHIFT{1'b0}}})
                 + $signed({{(OS_W-MUL_W){potco_q[MUL_W-1]}}, potco_q});
  assign sens1_c = $signed({{(OS_W-CAL_W-SENS_SHIFT){1'b0}}, cal.sens, {SENS_SHIFT{1'b0}}})
                 + $signed({{(OS_W-MUL_W){pstco_q[MUL_W-1]}}, pstco_q});

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_ok <= ok_c;
      s1_d1 <= raw_pressure;
      s1_dt <= dt_c;
    end
    if (en[1]) begin
      s2_ok    <= s1_ok;
      s2_d1    <= s1_d1;
      s2_pts   <= MUL_W'(s1_dt) * MUL_W'($signed({1'b0, cal.tempsens}));
      s2_potco <= MUL_W'(s1_dt) * MUL_W'($signed({1'b0, cal.offset_tco}));
      s2_pstco <= MUL_W'(s1_dt) * MUL_W'($signed({1'b0, cal.sens_tco}));
      s2_dtsq  <= dtsq_c[DTSQ_W-1:0];
    end
    if (en[2]) begin
      s3.ok    <= s2_ok;
      s3.d1    <= s2_d1;
      s3.temp  <= temp_c;
      s3.t2    <= t2_c;
      s3.off1  <= off1_c;
      s3.sens1 <= sens1_c;
    end
  end

endmodule

// ----- hw/rtl/bpc_corr.sv -----
// ----------------------------------------------------------------------------
// bpc_corr: low and very-low temperature corrections
// Three register stages: squares, OFF2/SENS2, corrected OFF and SENS.
// ----------------------------------------------------------------------------
module bpc_corr import bpc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output corr_t  out_data
);

  logic [2:0] v;
  logic [2:0] en;

  // stage 4
  logic signed [TEMP_W-1:0]   tx_c, ty_c;
  logic signed [2*TEMP_W-1:0] txsq_c, tysq_c;
  logic signed [TEMP_W:0]     tdiff_c;
  logic                       s4_ok, s4_low, s4_vlow;
  logic [RAW_W-1:0]           s4_d1;
  logic signed [TOUT_W-1:0]   s4_tout;
  logic signed [OS_W-1:0]     s4_off1, s4_sens1;
  logic [SQ_W-1:0]            s4_txsq, s4_tysq;

  // stage 5
  logic [KSQ_W-1:0]       off2_low, sens2_low, off2_vlow, sens2_vlow;
  logic [OS_W-1:0]        off2_c, sens2_c;
  logic                   s5_ok;
  logic [RAW_W-1:0]       s5_d1;
  logic signed [TOUT_W-1:0] s5_tout;
  logic signed [OS_W-1:0] s5_off1, s5_sens1;
  logic [OS_W-1:0]        s5_off2, s5_sens2;

  corr_t s6;

  assign en[2]     = !v[2] || out_ready;
  assign en[1]     = !v[1] || en[2];
  assign en[0]     = !v[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v[2];
  assign out_data  = s6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
    end
  end

  assign tx_c   = in_data.temp - TEMP_REF;
  assign ty_c   = in_data.temp + TEMP_VLOW;
  assign txsq_c = (2*TEMP_W)'(tx_c) * (2*TEMP_W)'(tx_c);
  assign tysq_c = (2*TEMP_W)'(ty_c) * (2*TEMP_W)'(ty_c);
  // TEMP - T2 stays far inside the 24-bit field, so sign extension is the saturation
  assign tdiff_c = $signed({in_data.temp[TEMP_W-1], in_data.temp})
                 - $signed({{(TEMP_W+1-T2_W){1'b0}}, in_data.t2});

  assign off2_low   = KSQ_W'(s4_txsq) * KSQ_W'(OFF2_LOW_K);
  assign sens2_low  = KSQ_W'(s4_txsq) * KSQ_W'(SENS2_LOW_K);
  assign off2_vlow  = KSQ_W'(s4_tysq) * KSQ_W'(OFF2_VLOW_K);
  assign sens2_vlow = KSQ_W'(s4_tysq) * KSQ_W'(SENS2_VLOW_K);

  always_comb begin
    off2_c  = '0;
    sens2_c = '0;
    if (s4_low) begin
      off2_c  = OS_W'(off2_low >> K2_SHIFT);
      sens2_c = OS_W'(sens2_low >> K2_SHIFT);
      if (s4_vlow) begin
        off2_c  = off2_c + OS_W'(off2_vlow);
        sens2_c = sens2_c + OS_W'(sens2_vlow);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s4_ok    <= in_data.ok;
      s4_d1    <= in_data.d1;
      s4_low   <= in_data.temp < TEMP_REF;
      s4_vlow  <= in_data.temp < -TEMP_VLOW;
      s4_tout  <= TOUT_W'(tdiff_c);
      s4_off1  <= in_data.off1;
      s4_sens1 <= in_data.sens1;
      s4_txsq  <= txsq_c[SQ_W-1:0];
      s4_tysq  <= tysq_c[SQ_W-1:0];
    end
    if (en[1]) begin
      s5_ok    <= s4_ok;
      s5_d1    <= s4_d1;
      s5_tout  <= s4_tout;
      s5_off1  <= s4_off1;
      s5_sens1 <= s4_sens1;
      s5_off2  <= off2_c;
      s5_sens2 <= sens2_c;
    end
    if (en[2]) begin
      s6.ok   <= s5_ok;
      s6.d1   <= s5_d1;
      s6.tout <= s5_tout;
      s6.off  <= s5_off1 - $signed(s5_off2);
      s6.sens <= s5_sens1 - $signed(s5_sens2);
    end
  end

endmodule

// ----- hw/rtl/bpc_press.sv -----
// ----------------------------------------------------------------------------
// bpc_press: pressure from D1, SENS and OFF
// Four register stages: split product, product sum, offset subtract, output.
// ----------------------------------------------------------------------------
module bpc_press import bpc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  corr_t   in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  localparam int PL_W = RAW_W + SPLIT_W;
  localparam int HI_W = OS_W - SPLIT_W;
  localparam int PH_W = RAW_W + 1 + HI_W;

  logic [3:0] v;
  logic [3:0] en;

  // stage 7: D1 times the low and high slices of SENS
  logic                     s7_ok;
  logic signed [TOUT_W-1:0] s7_tout;
  logic signed [OS_W-1:0]   s7_off;
  logic [PL_W-1:0]          s7_pl;
  logic signed [PH_W-1:0]   s7_ph;

  // stage 8
  logic                     s8_ok;
  logic signed [TOUT_W-1:0] s8_tout;
  logic signed [OS_W-1:0]   s8_off;
  logic signed [PROD_W-1:0] s8_prod;

  // stage 9
  logic signed [PROD_W-1:0] prod_b, prod_q;
  logic                     s9_ok;
  logic signed [TOUT_W-1:0] s9_tout;
  logic signed [ACC_W-1:0]  s9_acc;

  // stage 10
  logic signed [ACC_W-1:0]  acc_b, acc_q;
  result_t                  s10;

  assign en[3]     = !v[3] || out_ready;
  assign en[2]     = !v[2] || en[3];
  assign en[1]     = !v[1] || en[2];
  assign en[0]     = !v[0] || en[1];
  assign in_ready  = en[0];
  assign out_valid = v[3];
  assign out_data  = s10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      if (en[1]) v[1] <= v[0];
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
    end
  end

  // Truncate toward zero on both scalings
  assign prod_b = s8_prod
                + $signed({{(PROD_W-D1_SHIFT){1'b0}}, {D1_SHIFT{s8_prod[PROD_W-1]}}});
  assign prod_q = prod_b >>> D1_SHIFT;
  assign acc_b  = s9_acc
                + $signed({{(ACC_W-P_SHIFT){1'b0}}, {P_SHIFT{s9_acc[ACC_W-1]}}});
  assign acc_q  = acc_b >>> P_SHIFT;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s7_ok   <= in_data.ok;
      s7_tout <= in_data.tout;
      s7_off  <= in_data.off;
      s7_pl   <= PL_W'(in_data.d1) * PL_W'(in_data.sens[SPLIT_W-1:0]);
      s7_ph   <= PH_W'($signed({1'b0, in_data.d1}))
               * PH_W'($signed(in_data.sens[OS_W-1:SPLIT_W]));
    end
    if (en[1]) begin
      s8_ok   <= s7_ok;
      s8_tout <= s7_tout;
      s8_off  <= s7_off;
      s8_prod <= $signed({s7_ph[PROD_W-SPLIT_W-1:0], {SPLIT_W{1'b0}}})
               + $signed({{(PROD_W-PL_W){1'b0}}, s7_pl});
    end
    if (en[2]) begin
      s9_ok   <= s8_ok;
      s9_tout <= s8_tout;
      s9_acc  <= $signed(prod_q[ACC_W-1:0])
               - $signed({{(ACC_W-OS_W){s8_off[OS_W-1]}}, s8_off});
    end
    if (en[3]) begin
      // The pressure quotient stays inside 32 bits, so truncation is the saturation
      s10.result_valid      <= s9_ok;
      s10.temperature_centi <= s9_ok ? s9_tout : '0;
      s10.pressure_centi    <= s9_ok ? $signed(acc_q[P_W-1:0]) : '0;
    end
  end

endmodule

// ----- hw/rtl/baro_pressure_temp_compensation.sv -----
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation: second-order barometer compensation
// Turns raw pressure and temperature conversions into 0.01 degC / 0.01 mbar.
// ----------------------------------------------------------------------------
// Usage:
//   raw  : sink channel, one transfer carries a raw pressure (D1) and a raw
//          temperature (D2) conversion, 24 bits each.
//   comp : source channel, one transfer per raw transfer, in order, carrying
//          result_valid, temperature_centi and pressure_centi.
//   cfg  : write port for the six calibration words and the loaded flag;
//          write only while no item is in flight.
// comp.valid rises once a raw transfer has passed through all ten register
// stages. Throughput is one item per cycle while comp.ready is high; the
// longest stage is one 25x25 multiply (dT squared) or the D1 times SENS-high
// slice multiply.
// Reset clears the calibration registers (results read as not valid until
// calibration is loaded) and empties the pipeline.
// When comp stalls, each stage holds until the stage after it is free, so
// bubbles close up; raw.ready drops only once all ten stages hold items.
// Without calibration, or with a raw value of zero, the result has
// result_valid low and both values zero.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation import bpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CAL_W-1:0]   cfg_wdata,
  bpc_raw_if.sink            raw,
  bpc_comp_if.source         comp
);

  cal_t    cal;
  logic    front_valid, front_ready;
  front_t  front_data;
  logic    corr_valid, corr_ready;
  corr_t   corr_data;
  result_t res;

  // Calibration registers; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAL_SENS:       cal.sens       <= cfg_wdata;
        REG_CAL_OFFSET:     cal.offset     <= cfg_wdata;
        REG_CAL_SENS_TCO:   cal.sens_tco   <= cfg_wdata;
        REG_CAL_OFFSET_TCO: cal.offset_tco <= cfg_wdata;
        REG_CAL_TREF:       cal.tref       <= cfg_wdata;
        REG_CAL_TEMPSENS:   cal.tempsens   <= cfg_wdata;
        REG_CAL_LOADED:     cal.loaded     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // dT, TEMP, T2 and first-order OFF/SENS
  bpc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cal             (cal),
    .in_valid        (raw.valid),
    .in_ready        (raw.ready),
    .raw_pressure    (raw.raw_pressure),
    .raw_temperature (raw.raw_temperature),
    .out_valid       (front_valid),
    .out_ready       (front_ready),
    .out_data        (front_data)
  );

  // Low-temperature corrections to OFF and SENS
  bpc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_data   (front_data),
    .out_valid (corr_valid),
    .out_ready (corr_ready),
    .out_data  (corr_data)
  );

  // P = (D1*SENS/2^21 - OFF)/2^15, output register last
  bpc_press u_press (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (corr_valid),
    .in_ready  (corr_ready),
    .in_data   (corr_data),
    .out_valid (comp.valid),
    .out_ready (comp.ready),
    .out_data  (res)
  );

  assign comp.result_valid      = res.result_valid;
  assign comp.temperature_centi = res.temperature_centi;
  assign comp.pressure_centi    = res.pressure_centi;

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench for baro_pressure_temp_compensation
// Drives raw pressure/temperature pairs through the valid/ready channel under
// several calibration sets. Each result is checked field by field against an
// in-bench computation of the second-order compensation. Both sides idle in
// random bursts, and the run ends with a stretch at full rate.
// ----------------------------------------------------------------------------
module tb;
  import bpc_pkg::*;

  // Register index with no register behind it: the write must be dropped
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  // Compensation constants in 64-bit signed form
  localparam longint REF_CENTI     = 2000;
  localparam longint VLOW_CENTI    = 1500;
  localparam longint K_OFF2_LOW    = 61;
  localparam longint K_SENS2_LOW   = 29;
  localparam longint K_OFF2_VLOW   = 17;
  localparam longint K_SENS2_VLOW  = 9;
  localparam longint K_T2_HIGH     = 5;
  localparam longint K_T2_LOW      = 3;
  localparam longint DIV_TEMPSENS  = 64'sd1 <<< 23;
  localparam longint DIV_T2_HIGH   = 64'sd1 <<< 38;
  localparam longint DIV_T2_LOW    = 64'sd1 <<< 33;
  localparam longint DIV_D1        = 64'sd1 <<< 21;
  localparam longint DIV_P         = 64'sd1 <<< 15;
  localparam longint DIV_OFF_TCO   = 64;
  localparam longint DIV_SENS_TCO  = 128;
  localparam longint DIV_SQ        = 16;
  localparam longint GAIN_OFF      = 131072;
  localparam longint GAIN_SENS     = 65536;
  localparam longint GAIN_TREF     = 256;
  localparam longint TOUT_MIN      = -(64'sd1 <<< (TOUT_W - 1));
  localparam longint TOUT_MAX      = (64'sd1 <<< (TOUT_W - 1)) - 1;
  localparam longint P_MIN         = -(64'sd1 <<< (P_W - 1));
  localparam longint P_MAX         = (64'sd1 <<< (P_W - 1)) - 1;
  localparam longint RAW_MAX       = (64'sd1 <<< RAW_W) - 1;

  // Boundary calibration: tempsens of 2^13 makes 1024 counts one hundredth
  localparam int BND_TREF     = 20000;
  localparam int BND_TEMPSENS = 8192;
  localparam int BND_STEP     = 1024;
  localparam int BND_CENTER   = BND_TREF * 256;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int TAIL_CYCLES     = 30;
  localparam int RANDOM_ROUNDS   = 6;
  localparam int ROUND_ITEMS     = 60;
  localparam int FULL_RATE_ITEMS = 60;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CAL_W-1:0] cfg_wdata;

  bpc_raw_if  raw_ch ();
  bpc_comp_if comp_ch ();

  baro_pressure_temp_compensation u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .raw       (raw_ch),
    .comp      (comp_ch)
  );

  always #1 clk = ~clk;

  cal_t    cal_model;            // calibration as the block should hold it
  result_t expected_readings[$]; // compensated readings still owed, in order
  bit      idle_enable;          // random bursts of idling on both sides
  int      mismatches;
  int      stall_left;
  int      quiet_cycles;

  // Second-order compensation of one raw pair under the given calibration
  function automatic result_t compensate(input cal_t c, input logic [RAW_W-1:0] d1_raw,
                                         input logic [RAW_W-1:0] d2_raw);
    longint  d1, d2, sens_w, off_w, stco, otco, tref, tsens;
    longint  dt, temp, t2, off, sens, tx, ty, off2, sens2, p, tout;
    result_t r;
    r = '0;
    d1 = longint'(d1_raw);
    d2 = longint'(d2_raw);
    if (!c.loaded || d1 == 0 || d2 == 0) begin
      return r;
    end
    sens_w = longint'(c.sens);
    off_w  = longint'(c.offset);
    stco   = longint'(c.sens_tco);
    otco   = longint'(c.offset_tco);
    tref   = longint'(c.tref);
    tsens  = longint'(c.tempsens);

    dt   = d2 - tref * GAIN_TREF;
    temp = REF_CENTI + (dt * tsens) / DIV_TEMPSENS;
    if (temp >= REF_CENTI) begin
      t2 = (K_T2_HIGH * (dt * dt)) / DIV_T2_HIGH;
    end else begin
      t2 = (K_T2_LOW * (dt * dt)) / DIV_T2_LOW;
    end
    off  = off_w * GAIN_OFF + (otco * dt) / DIV_OFF_TCO;
    sens = sens_w * GAIN_SENS + (stco * dt) / DIV_SENS_TCO;

    // Cold corrections key off the first-order temperature
    if (temp < REF_CENTI) begin
      tx    = (temp - REF_CENTI) * (temp - REF_CENTI);
      off2  = (K_OFF2_LOW * tx) / DIV_SQ;
      sens2 = (K_SENS2_LOW * tx) / DIV_SQ;
      if (temp < -VLOW_CENTI) begin
        ty    = (temp + VLOW_CENTI) * (temp + VLOW_CENTI);
        off2  = off2 + K_OFF2_VLOW * ty;
        sens2 = sens2 + K_SENS2_VLOW * ty;
      end
      off  = off - off2;
      sens = sens - sens2;
    end

    p    = ((d1 * sens) / DIV_D1 - off) / DIV_P;
    tout = temp - t2;
    if (tout < TOUT_MIN) tout = TOUT_MIN;
    if (tout > TOUT_MAX) tout = TOUT_MAX;
    if (p < P_MIN) p = P_MIN;
    if (p > P_MAX) p = P_MAX;

    r.result_valid      = 1'b1;
    r.temperature_centi = tout[TOUT_W-1:0];
    r.pressure_centi    = p[P_W-1:0];
    return r;
  endfunction

  function automatic cal_t make_calibration(input int sens, input int off, input int stco,
                                            input int otco, input int tref, input int tsens,
                                            input bit loaded);
    cal_t c;
    c.sens       = sens[CAL_W-1:0];
    c.offset     = off[CAL_W-1:0];
    c.sens_tco   = stco[CAL_W-1:0];
    c.offset_tco = otco[CAL_W-1:0];
    c.tref       = tref[CAL_W-1:0];
    c.tempsens   = tsens[CAL_W-1:0];
    c.loaded     = loaded;
    return c;
  endfunction

  // Mostly random words, with zero and full scale showing up often
  function automatic logic [CAL_W-1:0] random_cal_word();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return CAL_W'($urandom_range(0, 65535));
  endfunction

  // Write one register; hold cfg_we high so back-to-back writes need no gap
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_CAL_SENS:       cal_model.sens       = data;
      REG_CAL_OFFSET:     cal_model.offset     = data;
      REG_CAL_SENS_TCO:   cal_model.sens_tco   = data;
      REG_CAL_OFFSET_TCO: cal_model.offset_tco = data;
      REG_CAL_TREF:       cal_model.tref       = data;
      REG_CAL_TEMPSENS:   cal_model.tempsens   = data;
      REG_CAL_LOADED:     cal_model.loaded     = data[0];
      default: ;
    endcase
  endtask

  // Drop valid and hold until every owed reading has come back
  task automatic quiesce();
    raw_ch.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
  endtask

  task automatic load_calibration(input cal_t c);
    quiesce();
    cfg_write(REG_CAL_SENS, c.sens);
    cfg_write(REG_CAL_OFFSET, c.offset);
    cfg_write(REG_CAL_SENS_TCO, c.sens_tco);
    cfg_write(REG_CAL_OFFSET_TCO, c.offset_tco);
    cfg_write(REG_CAL_TREF, c.tref);
    cfg_write(REG_CAL_TEMPSENS, c.tempsens);
    cfg_write(REG_CAL_LOADED, {{(CAL_W-1){1'b0}}, c.loaded});
    cfg_we <= 1'b0;
  endtask

  // Offer one raw pair and wait for its transfer; valid stays high afterwards
  // so the next pair can follow on the very next cycle
  task automatic send_conversion(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 15);
      raw_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    raw_ch.valid           <= 1'b1;
    raw_ch.raw_pressure    <= d1;
    raw_ch.raw_temperature <= d2;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    expected_readings.push_back(compensate(cal_model, d1, d2));
  endtask

  // Random pair: mostly a temperature reading spread around the reference
  // point so all three temperature regions show up, plus zeros and noise
  task automatic send_random_conversion();
    int unsigned pick;
    longint      d2;
    longint      span;
    logic [RAW_W-1:0] d1;
    pick = $urandom_range(0, 99);
    d1   = RAW_W'($urandom_range(1, 32'hFF_FFFF));
    if (pick < 4) begin
      send_conversion('0, RAW_W'($urandom));
    end else if (pick < 8) begin
      send_conversion(d1, '0);
    end else if (pick < 10) begin
      send_conversion('0, '0);
    end else if (pick < 30) begin
      send_conversion(RAW_W'($urandom), RAW_W'($urandom));
    end else begin
      span = longint'($urandom_range(0, (32'd1 << $urandom_range(6, 23)) - 1));
      d2   = longint'(cal_model.tref) * GAIN_TREF;
      d2   = $urandom_range(0, 1) ? d2 + span : d2 - span;
      if (d2 < 1) d2 = 1;
      if (d2 > RAW_MAX) d2 = RAW_MAX;
      send_conversion(d1, d2[RAW_W-1:0]);
    end
  endtask

  // Out of reset nothing is calibrated: every reading comes back invalid
  task automatic test_uncalibrated();
    send_conversion('1, '1);
    send_conversion(24'h80_0000, 24'h7F_FFFF);
    quiesce();
  endtask

  // Walk the thresholds at 20.00 and -15.00 degC, plus zero raw values
  task automatic test_temperature_regions();
    load_calibration(make_calibration(40000, 36000, 23000, 21000,
                                      BND_TREF, BND_TEMPSENS, 1'b1));
    send_conversion(24'd4000000, RAW_W'(BND_CENTER));
    send_conversion(24'd4000000, RAW_W'(BND_CENTER - BND_STEP));
    send_conversion(24'd4000000, RAW_W'(BND_CENTER - 3500 * BND_STEP));
    send_conversion(24'd4000000, RAW_W'(BND_CENTER - 3501 * BND_STEP));
    send_conversion(24'd4000000, 24'd1);
    send_conversion(24'd4000000, '1);
    send_conversion(24'd6000000, RAW_W'(BND_CENTER + 40 * BND_STEP));
    send_conversion('1, RAW_W'(BND_CENTER - 3500 * BND_STEP));
    send_conversion(24'd1, RAW_W'(BND_CENTER));
    send_conversion('0, RAW_W'(BND_CENTER));
    send_conversion(24'd5000000, '0);
    send_conversion('0, '0);
    quiesce();
  endtask

  // All-zero and all-ones calibration, a stray register index, and a
  // loaded write whose low bit is clear
  task automatic test_calibration_extremes();
    load_calibration(make_calibration(0, 0, 0, 0, 0, 0, 1'b1));
    send_conversion('1, '1);
    send_conversion(24'd1, 24'd1);
    load_calibration(make_calibration(65535, 65535, 65535, 65535, 65535, 65535, 1'b1));
    send_conversion('1, '1);
    send_conversion(24'd1, 24'd1);
    send_conversion(24'h80_0000, 24'h80_0000);
    quiesce();
    cfg_write(REG_UNUSED, 16'h0000);
    cfg_we <= 1'b0;
    send_conversion(24'h55_AA55, 24'hAA_55AA);
    quiesce();
    cfg_write(REG_CAL_LOADED, 16'hFFFE);
    cfg_we <= 1'b0;
    send_conversion(24'h55_AA55, 24'hAA_55AA);
    quiesce();
  endtask

  // Fresh calibration per round; every third round runs with no idling
  task automatic test_random_conversions();
    cal_t c;
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      if (round == 0) begin
        c = make_calibration(46372, 43981, 29059, 27842, 31553, 28165, 1'b1);
      end else begin
        c.sens       = random_cal_word();
        c.offset     = random_cal_word();
        c.sens_tco   = random_cal_word();
        c.offset_tco = random_cal_word();
        c.tref       = random_cal_word();
        c.tempsens   = random_cal_word();
        c.loaded     = ($urandom_range(0, 9) != 0);
      end
      load_calibration(c);
      idle_enable = (round % 3 != 2);
      for (int n = 0; n < ROUND_ITEMS; n++) send_random_conversion();
    end
    quiesce();
  endtask

  // Closing stretch: back-to-back transfers with neither side idling
  task automatic test_full_rate();
    load_calibration(make_calibration(46372, 43981, 29059, 27842, 31553, 28165, 1'b1));
    idle_enable = 1'b0;
    for (int n = 0; n < FULL_RATE_ITEMS; n++) send_random_conversion();
    quiesce();
  endtask

  // Sink side: accept, or stall for a random burst while idling is enabled
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      comp_ch.ready <= 1'b0;
    end else if (idle_enable && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      comp_ch.ready <= 1'b0;
    end else begin
      comp_ch.ready <= 1'b1;
    end
  end

  // Check every result transfer against the oldest owed reading
  always @(posedge clk) begin
    result_t want;
    if (!rst && comp_ch.valid && comp_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual valid=%0b temp=%0d press=%0d",
                 $time, comp_ch.result_valid, comp_ch.temperature_centi,
                 comp_ch.pressure_centi);
        mismatches++;
      end else begin
        want = expected_readings.pop_front();
        if (comp_ch.result_valid !== want.result_valid) begin
          $display("%0t: result_valid expected %0b actual %0b",
                   $time, want.result_valid, comp_ch.result_valid);
          mismatches++;
        end
        if (comp_ch.temperature_centi !== want.temperature_centi) begin
          $display("%0t: temperature_centi expected %0d actual %0d",
                   $time, want.temperature_centi, comp_ch.temperature_centi);
          mismatches++;
        end
        if (comp_ch.pressure_centi !== want.pressure_centi) begin
          $display("%0t: pressure_centi expected %0d actual %0d",
                   $time, want.pressure_centi, comp_ch.pressure_centi);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run once no transfer has happened for too long
  always @(posedge clk) begin
    if ((raw_ch.valid && raw_ch.ready) || (comp_ch.valid && comp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    // Drive every input to a known value before the first edge
    rst                    = 1'b1;
    cfg_we                 = 1'b0;
    cfg_index              = REG_CAL_SENS;
    cfg_wdata              = '0;
    raw_ch.valid           = 1'b0;
    raw_ch.raw_pressure    = '0;
    raw_ch.raw_temperature = '0;
    comp_ch.ready          = 1'b0;
    cal_model              = '0;
    idle_enable            = 1'b1;
    mismatches             = 0;
    stall_left             = 0;
    quiet_cycles           = 0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_uncalibrated();
    test_temperature_regions();
    test_calibration_extremes();
    test_random_conversions();
    test_full_rate();

    // Let the pipeline run on past its latency to catch stray results
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
